// File: sv/nesm189_pkg.sv
// Shared types and constants for the mapper 189 bank and scanline IRQ block.
`timescale 1ns / 1ps
package nesm189_pkg;

   localparam int PRG_PAGES_W = 10;
   localparam int CHR_PAGES_W = 12;
   localparam int DIVIDEND_W  = 9;
   localparam int REM_W       = CHR_PAGES_W;

   localparam logic [PRG_PAGES_W-1:0] PRG_PAGES_RESET = 10'd32;
   localparam logic [CHR_PAGES_W-1:0] CHR_PAGES_RESET = 12'd256;

   localparam logic CSR_PRG_PAGES = 1'b0;
   localparam logic CSR_CHR_PAGES = 1'b1;

   localparam logic [15:0] ADDR_SELECT     = 16'h8000;
   localparam logic [15:0] ADDR_BANK_DATA  = 16'h8001;
   localparam logic [15:0] ADDR_IRQ_COUNT  = 16'hC000;
   localparam logic [15:0] ADDR_IRQ_RELOAD = 16'hC001;
   localparam logic [15:0] ADDR_IRQ_OFF    = 16'hE000;
   localparam logic [15:0] ADDR_IRQ_ON     = 16'hE001;
   localparam logic [15:0] ADDR_LOW_FIRST  = 16'h4100;
   localparam logic [15:0] ADDR_LOW_LAST   = 16'h41FF;

   localparam logic [7:0] SEL_CHR01 = 8'h40;
   localparam logic [7:0] SEL_CHR23 = 8'h41;
   localparam logic [7:0] SEL_CHR4  = 8'h42;
   localparam logic [7:0] SEL_CHR7  = 8'h45;
   localparam logic [7:0] SEL_PRG2  = 8'h46;
   localparam logic [7:0] SEL_PRG1  = 8'h47;

   localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

   typedef enum logic [1:0] {
      ACT_INIT,
      ACT_MAPPER,
      ACT_LOW,
      ACT_HSYNC
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                   start;
      logic [DIVIDEND_W-1:0]  dividend;
      logic [CHR_PAGES_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [REM_W-1:0] remainder;
   } mod_sts_type;

endpackage

// File: sv/nesm189_mod_unit.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
module nesm189_mod_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  nesm189_pkg::mod_req_type req,
   output nesm189_pkg::mod_sts_type sts
);
   import nesm189_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0]  shift_ff, shift_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [CHR_PAGES_W-1:0] div_ff, div_in;
   logic [REM_W:0]         trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      trial    = {rem_ff, shift_ff[DIVIDEND_W-1]};
      if (req.start) begin
         busy_in  = 1'b1;
         cnt_in   = 4'(DIVIDEND_W);
         shift_in = req.dividend;
         rem_in   = '0;
         div_in   = req.divisor;
      end else if (busy_ff) begin
         shift_in = {shift_ff[DIVIDEND_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = REM_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[REM_W-1:0];
         end
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign sts.busy      = busy_ff;
   assign sts.done      = done_ff;
   assign sts.remainder = rem_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("remainder done without a running division");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");

endmodule

// File: sv/nes_mapper189_bank_irq.sv
// Mapper 189 bank switching and scanline IRQ block, top level.
// Input is held off until the last item has loaded its result. J = 0..4 remainder jobs
// (two-slot character write J=2, low-range write J=4, other bank writes J=1).
// Each job runs 9 steps of the shared remainder unit.
// The result register frees the input side while a result waits to be taken.
// Reset: page counts 32 and 256, banks, select and IRQ count, reload and enable cleared.
`timescale 1ns / 1ps
module nes_mapper189_bank_irq (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // action
   input  logic [39:0]  req_tdata,   // address, data, scanline, rendering_on, zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // prg_banks, chr_banks_01, _23, _45, _67,
                                     // irq_request, zero pad
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [11:0]  csr_wdata
);
   import nesm189_pkg::*;

   state_type              state_ff, state_in;
   logic [PRG_PAGES_W-1:0] prg_pages_ff, prg_pages_in;
   logic [CHR_PAGES_W-1:0] chr_pages_ff, chr_pages_in;
   logic [7:0]             select_ff, select_in;
   logic [7:0]             prg_bank_ff [4];
   logic [7:0]             prg_bank_in [4];
   logic [8:0]             chr_bank_ff [8];
   logic [8:0]             chr_bank_in [8];
   logic [7:0]             irq_count_ff, irq_count_in;
   logic [7:0]             irq_reload_ff, irq_reload_in;
   logic                   irq_on_ff, irq_on_in;
   logic                   irq_ff, irq_in;
   action_type             act_ff, act_in;
   logic [7:0]             data_ff, data_in;
   logic                   is_chr_ff, is_chr_in;
   logic                   low_ff, low_in;
   logic [2:0]             base_ff, base_in;
   logic [1:0]             job_ff, job_in;
   logic [1:0]             job_last_ff, job_last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [111:0]           rsp_data_ff, rsp_data_in;

   logic        req_fire;
   logic        has_job;
   logic        fin_load;
   logic        mod_start;
   logic [7:0]  count_dec;
   logic [15:0] req_address;
   logic [7:0]  req_data;
   logic [8:0]  req_scanline;
   logic        req_render;
   logic [2:0]  slot;
   mod_req_type mod_req;
   mod_sts_type mod_sts;

   assign req_address  = req_tdata[15:0];
   assign req_data     = req_tdata[23:16];
   assign req_scanline = req_tdata[32:24];
   assign req_render   = req_tdata[33];
   assign req_fire     = req_tvalid && req_tready;
   assign count_dec    = irq_count_ff - 8'd1;

   nesm189_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .sts   (mod_sts)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = has_job ? ST_ISSUE : ST_FINISH;
            end
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (mod_sts.done) begin
               state_in = (job_ff == job_last_ff) ? ST_FINISH : ST_ISSUE;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      mod_start  = 1'b0;
      fin_load   = 1'b0;
      case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_ISSUE:  mod_start  = 1'b1;
         ST_WAIT:   ;
         ST_FINISH: fin_load   = !rsp_valid_ff || rsp_tready;
         default:   ;
      endcase
   end

   // operands of the current remainder job
   always_comb begin
      mod_req.start = mod_start;
      if (low_ff) begin
         mod_req.dividend = 9'({data_ff[5:4], job_ff});
         slot             = 3'(job_ff);
      end else begin
         mod_req.dividend = {1'b0, data_ff} + 9'(job_ff);
         slot             = base_ff + 3'(job_ff);
      end
      mod_req.divisor = is_chr_ff ? chr_pages_ff : CHR_PAGES_W'(prg_pages_ff);
   end

   always_comb begin
      prg_pages_in  = prg_pages_ff;
      chr_pages_in  = chr_pages_ff;
      select_in     = select_ff;
      prg_bank_in   = prg_bank_ff;
      chr_bank_in   = chr_bank_ff;
      irq_count_in  = irq_count_ff;
      irq_reload_in = irq_reload_ff;
      irq_on_in     = irq_on_ff;
      irq_in        = irq_ff;
      act_in        = act_ff;
      data_in       = data_ff;
      is_chr_in     = is_chr_ff;
      low_in        = low_ff;
      base_in       = base_ff;
      job_in        = job_ff;
      job_last_in   = job_last_ff;
      has_job       = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_we) begin
         if (csr_index == CSR_PRG_PAGES) begin
            prg_pages_in = csr_wdata[PRG_PAGES_W-1:0];
         end else begin
            chr_pages_in = csr_wdata;
         end
      end

      if (req_fire) begin
         act_in      = action_type'(req_tuser);
         data_in     = req_data;
         is_chr_in   = 1'b0;
         low_in      = 1'b0;
         base_in     = '0;
         job_in      = '0;
         job_last_in = '0;
         irq_in      = 1'b0;
         case (action_type'(req_tuser))
            ACT_INIT: begin
               prg_bank_in[0] = 8'd0;
               prg_bank_in[1] = 8'd1;
               prg_bank_in[2] = 8'(prg_pages_ff - 10'd2);
               prg_bank_in[3] = 8'(prg_pages_ff - 10'd1);
               if (chr_pages_ff != '0) begin
                  for (int i = 0; i < 8; i++) begin
                     chr_bank_in[i] = 9'(i);
                  end
               end
               irq_count_in  = '0;
               irq_reload_in = '0;
               irq_on_in     = 1'b0;
            end
            ACT_MAPPER: begin
               case (req_address)
                  ADDR_SELECT:     select_in     = req_data;
                  ADDR_IRQ_COUNT:  irq_count_in  = req_data;
                  ADDR_IRQ_RELOAD: irq_reload_in = req_data;
                  ADDR_IRQ_OFF:    irq_on_in     = 1'b0;
                  ADDR_IRQ_ON:     irq_on_in     = 1'b1;
                  ADDR_BANK_DATA: begin
                     if ((select_ff == SEL_CHR01 || select_ff == SEL_CHR23)
                         && chr_pages_ff != '0) begin
                        has_job     = 1'b1;
                        is_chr_in   = 1'b1;
                        base_in     = (select_ff == SEL_CHR01) ? 3'd0 : 3'd2;
                        job_last_in = 2'd1;
                     end else if ((select_ff inside {[SEL_CHR4:SEL_CHR7]})
                                  && chr_pages_ff != '0) begin
                        has_job   = 1'b1;
                        is_chr_in = 1'b1;
                        base_in   = select_ff[2:0] + 3'd2;
                     end else if ((select_ff == SEL_PRG2 || select_ff == SEL_PRG1)
                                  && prg_pages_ff != '0) begin
                        has_job = 1'b1;
                        base_in = (select_ff == SEL_PRG2) ? 3'd2 : 3'd1;
                     end
                  end
                  default: ;
               endcase
            end
            ACT_LOW: begin
               if (req_address >= ADDR_LOW_FIRST && req_address <= ADDR_LOW_LAST
                   && prg_pages_ff != '0) begin
                  has_job     = 1'b1;
                  low_in      = 1'b1;
                  job_last_in = 2'd3;
               end
            end
            ACT_HSYNC: begin
               if (irq_on_ff && req_scanline <= LAST_VISIBLE_LINE && req_render) begin
                  if (count_dec == 8'd0) begin
                     irq_count_in = irq_reload_ff;
                     irq_in       = 1'b1;
                  end else begin
                     irq_count_in = count_dec;
                  end
               end
            end
            default: ;
         endcase
      end

      // write back the finished remainder and advance to the next job
      if (state_ff == ST_WAIT && mod_sts.done) begin
         if (is_chr_ff) begin
            chr_bank_in[slot] = mod_sts.remainder[8:0];
         end else begin
            prg_bank_in[slot[1:0]] = mod_sts.remainder[7:0];
         end
         if (job_ff != job_last_ff) begin
            job_in = job_ff + 2'd1;
         end
      end

      if (fin_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, irq_ff,
                         chr_bank_ff[7], chr_bank_ff[6], chr_bank_ff[5], chr_bank_ff[4],
                         chr_bank_ff[3], chr_bank_ff[2], chr_bank_ff[1], chr_bank_ff[0],
                         prg_bank_ff[3], prg_bank_ff[2], prg_bank_ff[1], prg_bank_ff[0]};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prg_pages_ff  <= PRG_PAGES_RESET;
         chr_pages_ff  <= CHR_PAGES_RESET;
         select_ff     <= '0;
         prg_bank_ff   <= '{default: '0};
         chr_bank_ff   <= '{default: '0};
         irq_count_ff  <= '0;
         irq_reload_ff <= '0;
         irq_on_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         job_ff        <= '0;
         job_last_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         prg_pages_ff  <= prg_pages_in;
         chr_pages_ff  <= chr_pages_in;
         select_ff     <= select_in;
         prg_bank_ff   <= prg_bank_in;
         chr_bank_ff   <= chr_bank_in;
         irq_count_ff  <= irq_count_in;
         irq_reload_ff <= irq_reload_in;
         irq_on_ff     <= irq_on_in;
         rsp_valid_ff  <= rsp_valid_in;
         job_ff        <= job_in;
         job_last_ff   <= job_last_in;
      end
      irq_ff      <= irq_in;
      act_ff      <= act_in;
      data_ff     <= data_in;
      is_chr_ff   <= is_chr_in;
      low_ff      <= low_in;
      base_ff     <= base_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_irq_only_hsync: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && irq_ff) |-> (act_ff == ACT_HSYNC))
      else $error("irq pulse on an item that is not an hsync tick");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mod_sts.done |-> (state_ff == ST_WAIT))
      else $error("remainder finished outside the wait state");

   a_job_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE || state_ff == ST_WAIT) |-> (job_ff <= job_last_ff))
      else $error("job index past the last job");

   a_issue_idle_unit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> !mod_sts.busy)
      else $error("remainder job issued while the unit is busy");

endmodule

// File: tb/nes_mapper189_bank_irq_tb.sv
// Testbench for the mapper 189 bank and IRQ block: directed table, then random items.
`timescale 1ns / 1ps
module nes_mapper189_bank_irq_tb;
   import nesm189_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 150;
   localparam int NUM_PHASES  = 6;
   localparam int SETTLE      = 60;

   localparam logic [7:0] SEL_CHR5 = SEL_CHR4 + 8'd1;
   localparam logic [7:0] SEL_CHR6 = SEL_CHR4 + 8'd2;

   typedef struct packed {
      logic        irq;
      logic [17:0] chr67;
      logic [17:0] chr45;
      logic [17:0] chr23;
      logic [17:0] chr01;
      logic [31:0] prg;
   } bank_result_type;

   typedef struct {
      action_type      act;
      logic [15:0]     addr;
      logic [7:0]      data;
      logic [8:0]      line;
      logic            render;
      logic            fixed;
      bank_result_type want;
   } stim_row_type;

   localparam bank_result_type AFTER_RESET = '0;
   localparam bank_result_type AFTER_INIT  = '{irq: 1'b0, chr67: 18'hE06, chr45: 18'hA04,
                                          chr23: 18'h602, chr01: 18'h200, prg: 32'h1F1E0100};
   localparam bank_result_type LOW_TOP     = '{irq: 1'b0, chr67: 18'hE06, chr45: 18'hA04,
                                          chr23: 18'h602, chr01: 18'h200, prg: 32'h0F0E0D0C};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser = ACT_INIT;
   logic [39:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic         csr_index = CSR_PRG_PAGES;
   logic [11:0]  csr_wdata = '0;

   // predicted mapper state
   logic [9:0]  prg_pages = PRG_PAGES_RESET;
   logic [11:0] chr_pages = CHR_PAGES_RESET;
   logic [7:0]  sel_q = '0;
   logic [7:0]  prg_q [4] = '{default: '0};
   logic [8:0]  chr_q [8] = '{default: '0};
   logic [7:0]  irq_cnt = '0;
   logic [7:0]  irq_rel = '0;
   logic        irq_en = 1'b0;

   bank_result_type bank_results_due [$];
   int              mismatches = 0;
   int              items_sent = 0;
   int              cycles = 0;
   int              ready_hold = 0;
   logic            calm = 1'b0;

   stim_row_type dir_rows [25] = '{
      '{ACT_HSYNC,  16'h0000,        8'h00, 9'd0,   1'b1, 1'b1, AFTER_RESET},
      '{ACT_MAPPER, ADDR_BANK_DATA,  8'hA5, 9'd0,   1'b0, 1'b1, AFTER_RESET},
      '{ACT_INIT,   16'h0000,        8'h00, 9'd0,   1'b0, 1'b1, AFTER_INIT},
      '{ACT_LOW,    ADDR_LOW_FIRST,  8'h30, 9'd0,   1'b0, 1'b1, LOW_TOP},
      '{ACT_LOW,    ADDR_LOW_LAST,   8'hFF, 9'd0,   1'b0, 1'b0, AFTER_RESET},
      '{ACT_LOW,    16'h40FF,        8'h10, 9'd0,   1'b0, 1'b0, AFTER_RESET},
      '{ACT_LOW,    16'h4200,        8'h20, 9'd0,   1'b0, 1'b0, AFTER_RESET},
      '{ACT_MAPPER, ADDR_SELECT,     SEL_CHR01, 9'd0, 1'b0, 1'b0, AFTER_RESET},
      '{ACT_MAPPER, ADDR_BANK_DATA,  8'hFF, 9'd0,   1'b0, 1'b0, AFTER_RESET},
      '{ACT_MAPPER, ADDR_SELECT,     SEL_CHR23, 9'd0, 1'b0, 1'b0, AFTER_RESET},
      '{ACT_MAPPER, ADDR_BANK_DATA,  8'h00, 9'd0,   1'b0, 1'b0, AFTER_RESET},
      '{ACT_MAPPER, ADDR_SELECT,     SEL_CHR4, 9'd0, 1'b0, 1'b0, AFTER_RESET},
      '{ACT_MAPPER, ADDR_BANK_DATA,  8'h80, 9'd0,   1'b0, 1'b0, AFTER_RESET},
      '{ACT_MAPPER, ADDR_SELECT,     SEL_PRG2, 9'd0, 1'b0, 1'b0, AFTER_RESET},
      '{ACT_MAPPER, ADDR_BANK_DATA,  8'hFF, 9'd0,   1'b0, 1'b0, AFTER_RESET},
      '{ACT_MAPPER, ADDR_SELECT,     SEL_PRG1 + 8'd1, 9'd0, 1'b0, 1'b0, AFTER_RESET},
      '{ACT_MAPPER, ADDR_BANK_DATA,  8'h55, 9'd0,   1'b0, 1'b0, AFTER_RESET},
      '{ACT_MAPPER, ADDR_IRQ_COUNT,  8'h02, 9'd0,   1'b0, 1'b0, AFTER_RESET},
      '{ACT_MAPPER, ADDR_IRQ_RELOAD, 8'h03, 9'd0,   1'b0, 1'b0, AFTER_RESET},
      '{ACT_MAPPER, ADDR_IRQ_ON,     8'h00, 9'd0,   1'b0, 1'b0, AFTER_RESET},
      '{ACT_HSYNC,  16'hFFFF,        8'hFF, LAST_VISIBLE_LINE, 1'b1, 1'b0, AFTER_RESET},
      '{ACT_HSYNC,  16'h0000,        8'h00, 9'd240, 1'b1, 1'b0, AFTER_RESET},
      '{ACT_HSYNC,  16'h0000,        8'h00, 9'd0,   1'b0, 1'b0, AFTER_RESET},
      '{ACT_HSYNC,  16'h0000,        8'h00, LAST_VISIBLE_LINE, 1'b1, 1'b0, AFTER_RESET},
      '{ACT_MAPPER, 16'hFFFF,        8'hFF, 9'd511, 1'b1, 1'b0, AFTER_RESET}
   };

   nes_mapper189_bank_irq DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void put_prg(int slot, int v);
      if (prg_pages != 0) prg_q[slot] = 8'(v % int'(prg_pages));
   endfunction

   function automatic void put_chr(int slot, int v);
      if (chr_pages != 0) chr_q[slot] = 9'(v % int'(chr_pages));
   endfunction

   function automatic bank_result_type step_mapper(action_type act, logic [15:0] addr,
                                                   logic [7:0] data, logic [8:0] line,
                                                   logic render);
      bank_result_type r;
      logic            fire;
      fire = 1'b0;
      r = '0;
      case (act)
         ACT_INIT: begin
            prg_q[0] = 8'd0;
            prg_q[1] = 8'd1;
            prg_q[2] = 8'(prg_pages - 10'd2);
            prg_q[3] = 8'(prg_pages - 10'd1);
            if (chr_pages != 0)
               for (int i = 0; i < 8; i++) chr_q[i] = 9'(i);
            irq_cnt = '0;
            irq_rel = '0;
            irq_en = 1'b0;
         end
         ACT_MAPPER: begin
            case (addr)
               ADDR_SELECT:     sel_q = data;
               ADDR_IRQ_COUNT:  irq_cnt = data;
               ADDR_IRQ_RELOAD: irq_rel = data;
               ADDR_IRQ_OFF:    irq_en = 1'b0;
               ADDR_IRQ_ON:     irq_en = 1'b1;
               ADDR_BANK_DATA: begin
                  case (sel_q)
                     SEL_CHR01: begin
                        put_chr(0, data);
                        put_chr(1, int'(data) + 1);
                     end
                     SEL_CHR23: begin
                        put_chr(2, data);
                        put_chr(3, int'(data) + 1);
                     end
                     SEL_CHR4: put_chr(4, data);
                     SEL_CHR5: put_chr(5, data);
                     SEL_CHR6: put_chr(6, data);
                     SEL_CHR7: put_chr(7, data);
                     SEL_PRG2: put_prg(2, data);
                     SEL_PRG1: put_prg(1, data);
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end
         ACT_LOW: begin
            if (addr >= ADDR_LOW_FIRST && addr <= ADDR_LOW_LAST)
               for (int i = 0; i < 4; i++) put_prg(i, 4 * int'(data[5:4]) + i);
         end
         default: begin
            if (irq_en && line <= LAST_VISIBLE_LINE && render) begin
               irq_cnt = irq_cnt - 8'd1;
               if (irq_cnt == 0) begin
                  irq_cnt = irq_rel;
                  fire = 1'b1;
               end
            end
         end
      endcase
      r.prg   = {prg_q[3], prg_q[2], prg_q[1], prg_q[0]};
      r.chr01 = {chr_q[1], chr_q[0]};
      r.chr23 = {chr_q[3], chr_q[2]};
      r.chr45 = {chr_q[5], chr_q[4]};
      r.chr67 = {chr_q[7], chr_q[6]};
      r.irq   = fire;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_item(action_type act, logic [15:0] addr, logic [7:0] data,
                            logic [8:0] line, logic render, logic fixed,
                            bank_result_type want);
      int              gap;
      bank_result_type r;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {6'b0, render, line, data, addr};
      do @(posedge clock); while (!req_tready);
      r = step_mapper(act, addr, data, line, render);
      bank_results_due.push_back(fixed ? want : r);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (bank_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [11:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_PRG_PAGES) prg_pages = value[9:0];
      else chr_pages = value;
   endtask

   function automatic logic [8:0] pick_line(logic visible);
      if (visible && $urandom_range(0, 99) < 85) return 9'($urandom_range(0, 239));
      if ($urandom_range(0, 99) < 85) return 9'($urandom_range(0, 261));
      return 9'($urandom_range(0, 511));
   endfunction

   task automatic hsync_run(int n);
      for (int i = 0; i < n; i++)
         send_item(ACT_HSYNC, 16'($urandom), 8'($urandom), pick_line(1'b1),
                   $urandom_range(0, 99) < 90, 1'b0, AFTER_RESET);
   endtask

   task automatic random_sequence();
      int          kind;
      logic [7:0]  sel;
      logic [15:0] addr;
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
         sel = $urandom_range(0, 99) < 85 ? SEL_CHR01 + 8'($urandom_range(0, 7))
                                          : 8'($urandom);
         send_item(ACT_MAPPER, ADDR_SELECT, sel, pick_line(1'b0), 1'($urandom), 1'b0,
                   AFTER_RESET);
         send_item(ACT_MAPPER, ADDR_BANK_DATA, 8'($urandom), pick_line(1'b0), 1'($urandom),
                   1'b0, AFTER_RESET);
      end else if (kind < 35) begin
         addr = $urandom_range(0, 99) < 80 ? ADDR_LOW_FIRST + 16'($urandom_range(0, 255))
                                           : 16'($urandom_range(16'h4000, 16'h42FF));
         send_item(ACT_LOW, addr, 8'($urandom), pick_line(1'b0), 1'($urandom), 1'b0,
                   AFTER_RESET);
      end else if (kind < 55) begin
         send_item(ACT_MAPPER, ADDR_IRQ_COUNT,
                   $urandom_range(0, 9) < 8 ? 8'($urandom_range(0, 8)) : 8'($urandom),
                   pick_line(1'b0), 1'($urandom), 1'b0, AFTER_RESET);
         send_item(ACT_MAPPER, ADDR_IRQ_RELOAD,
                   $urandom_range(0, 9) < 8 ? 8'($urandom_range(0, 8)) : 8'($urandom),
                   pick_line(1'b0), 1'($urandom), 1'b0, AFTER_RESET);
         send_item(ACT_MAPPER, ADDR_IRQ_ON, 8'($urandom), pick_line(1'b0), 1'($urandom),
                   1'b0, AFTER_RESET);
         hsync_run($urandom_range(1, 20));
      end else if (kind < 75) begin
         hsync_run($urandom_range(1, 6));
      end else if (kind < 80) begin
         send_item(ACT_INIT, 16'($urandom), 8'($urandom), pick_line(1'b0), 1'($urandom),
                   1'b0, AFTER_RESET);
      end else if (kind < 85) begin
         send_item(ACT_MAPPER, $urandom_range(0, 1) ? ADDR_IRQ_ON : ADDR_IRQ_OFF,
                   8'($urandom), pick_line(1'b0), 1'($urandom), 1'b0, AFTER_RESET);
      end else begin
         send_item(action_type'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
                   9'($urandom), 1'($urandom), 1'b0, AFTER_RESET);
      end
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // result side: check transfers, then pick the next ready pattern
   always @(posedge clock) begin
      bank_result_type got, want;
      int              r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[104:0];
         if (bank_results_due.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, got);
            mismatches++;
         end else begin
            want = bank_results_due.pop_front();
            check_field("prg_banks", want.prg, got.prg);
            check_field("chr_banks_01", want.chr01, got.chr01);
            check_field("chr_banks_23", want.chr23, got.chr23);
            check_field("chr_banks_45", want.chr45, got.chr45);
            check_field("chr_banks_67", want.chr67, got.chr67);
            check_field("irq_request", want.irq, got.irq);
         end
      end
      if (ready_hold != 0) begin
         ready_hold--;
      end else begin
         r = $urandom_range(0, 99);
         if (calm || r < 60) begin
            rsp_tready <= 1'b1;
            ready_hold = $urandom_range(0, 30);
         end else if (r < 92) begin
            rsp_tready <= 1'b0;
            ready_hold = $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b0;
            ready_hold = $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[nes_mapper189_bank_irq] ERROR");
         $finish;
      end
   end

   initial begin
      int   prg_cfg [NUM_PHASES];
      int   chr_cfg [NUM_PHASES];
      int   phase_start;
      logic paused;
      prg_cfg = '{2, 512, 3, 255, 100, 0};
      chr_cfg = '{0, 2048, 1, 300, 7, 0};
      prg_cfg[NUM_PHASES-1] = $urandom_range(2, 512);
      chr_cfg[NUM_PHASES-1] = $urandom_range(0, 2048);
      paused = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i])
         send_item(dir_rows[i].act, dir_rows[i].addr, dir_rows[i].data, dir_rows[i].line,
                   dir_rows[i].render, dir_rows[i].fixed, dir_rows[i].want);
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         write_csr(CSR_PRG_PAGES, 12'(prg_cfg[p]));
         write_csr(CSR_CHR_PAGES, 12'(chr_cfg[p]));
         calm = (p == 2);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            random_sequence();
            // hold off the sender once until the block has caught up
            if (p == 3 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
               drain();
               paused = 1'b1;
            end
         end
      end
      calm = 1'b0;
      drain();
      if (mismatches == 0 && bank_results_due.size() == 0)
         $display("[nes_mapper189_bank_irq] OK");
      else
         $display("[nes_mapper189_bank_irq] ERROR");
      $finish;
   end

endmodule

// File: filelist.f
sv/nesm189_pkg.sv
sv/nesm189_mod_unit.sv
sv/nes_mapper189_bank_irq.sv
tb/nes_mapper189_bank_irq_tb.sv
